// ----- rtl/mpspd_pkg.sv -----
// ----------------------------------------------------------------------------
// mpspd_pkg
// Types and constants shared by the program stream PES deframer.
// ----------------------------------------------------------------------------
package mpspd_pkg;

    localparam logic [31:0] CODE_VIDEO = 32'h0000_01E0;
    localparam logic [31:0] CODE_AUDIO = 32'h0000_01C0;

    localparam logic [1:0] PHASE_LEN_HI  = 2'd0;
    localparam logic [1:0] PHASE_LEN_LO  = 2'd1;
    localparam logic [1:0] PHASE_PAYLOAD = 2'd2;
    localparam logic [1:0] PHASE_UNUSED  = 2'd3;

    localparam logic KIND_VIDEO = 1'b0;
    localparam logic KIND_AUDIO = 1'b1;

    typedef struct packed {
        logic [31:0] window;
        logic [1:0]  phase;
        logic [15:0] pkt_len;
        logic [15:0] taken;
        logic        active;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [7:0] payload;
        logic       kind;
        logic       last;
        logic       empty;
    } t_result;

endpackage

// ----- rtl/mpspd_parse.sv -----
// ----------------------------------------------------------------------------
// mpspd_parse
// Next-state and result logic for one stream byte: start-code search,
// length capture and payload pass-through.
// ----------------------------------------------------------------------------
module mpspd_parse (
    input  mpspd_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    output mpspd_pkg::t_state  o_state,
    output mpspd_pkg::t_result o_result
);
    import mpspd_pkg::*;

    logic        matched;
    logic        is_audio;
    logic [15:0] len_new;
    logic [15:0] taken_new;

    assign is_audio  = (i_state.window == CODE_AUDIO);
    assign matched   = (i_state.window == CODE_VIDEO) || is_audio;
    assign len_new   = {i_state.pkt_len[7:0], i_byte};
    assign taken_new = i_state.taken + 16'd1;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (!matched) begin
            o_state.window = {i_state.window[23:0], i_byte};
            o_state.phase  = PHASE_LEN_HI;
        end else begin
            o_state.active = is_audio ? KIND_AUDIO : KIND_VIDEO;
            case (i_state.phase)
                PHASE_LEN_HI: begin
                    o_state.pkt_len = len_new;
                    o_state.phase   = PHASE_LEN_LO;
                end
                PHASE_LEN_LO: begin
                    o_state.pkt_len = len_new;
                    o_state.phase   = PHASE_PAYLOAD;
                    o_state.taken   = '0;
                    if (len_new == 16'd0) begin
                        o_result.valid  = 1'b1;
                        o_result.kind   = o_state.active;
                        o_result.last   = 1'b1;
                        o_result.empty  = 1'b1;
                        o_state.window  = '0;
                        o_state.phase   = PHASE_LEN_HI;
                        o_state.pkt_len = '0;
                    end
                end
                PHASE_PAYLOAD, PHASE_UNUSED: begin
                    o_result.valid   = 1'b1;
                    o_result.payload = i_byte;
                    o_result.kind    = o_state.active;
                    if (taken_new >= i_state.pkt_len) begin
                        o_result.last   = 1'b1;
                        o_state.window  = '0;
                        o_state.phase   = PHASE_LEN_HI;
                        o_state.pkt_len = '0;
                        o_state.taken   = '0;
                    end else begin
                        o_state.taken = taken_new;
                    end
                end
                default: begin
                    o_state = i_state;
                end
            endcase
        end
    end

endmodule

// ----- rtl/mpeg_ps_pes_deframer.sv -----
// ----------------------------------------------------------------------------
// mpeg_ps_pes_deframer
// Program stream PES deframer: passes on video (E0) and audio (C0) payload
// bytes tagged with stream kind, packet end and empty-packet flags.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the output side keeps taking results, and
// gives at most one result per byte. A byte is held in the input register,
// where the start-code compare, length capture and byte counter update are
// done, and moves on into the result register once the output side can take
// it; a stall there holds the byte in the input register. Header and
// length bytes give no result; a zero-length packet gives one empty marker.
// ----------------------------------------------------------------------------
module mpeg_ps_pes_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_stream_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_stream_kind,
    output logic       o_packet_end,
    output logic       o_empty_packet
);
    import mpspd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    logic       r_out_valid;
    logic [7:0] r_out_payload;
    logic       r_out_kind;
    logic       r_out_last;
    logic       r_out_empty;
    logic       advance;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    mpspd_parse u_parse (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= n_result.valid;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_stream_byte;
        end
        if (advance && n_result.valid) begin
            r_out_payload <= n_result.payload;
            r_out_kind    <= n_result.kind;
            r_out_last    <= n_result.last;
            r_out_empty   <= n_result.empty;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_payload_byte = r_out_payload;
    assign o_stream_kind  = r_out_kind;
    assign o_packet_end   = r_out_last;
    assign o_empty_packet = r_out_empty;

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid && !r_in_valid)
        else $error("pipeline not empty after reset");

    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_packet |-> o_packet_end && o_payload_byte == 8'd0)
        else $error("empty marker without packet end or with payload");

    a_search_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.window != CODE_VIDEO && r_state.window != CODE_AUDIO)
        |-> r_state.phase == PHASE_LEN_HI && r_state.taken == 16'd0
            && r_state.pkt_len == 16'd0)
        else $error("packet state left over while searching");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PHASE_PAYLOAD |-> r_state.taken < r_state.pkt_len)
        else $error("payload count reached packet length without closing");

    a_no_unused_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase != PHASE_UNUSED)
        else $error("length phase took the unused code");

endmodule
